### hdl/ccp_pkg.sv
// Package for the 5-bit coefficient compress and pack block.
// Holds the shared widths, default parameter values and the queue entry type.
// No dependencies.
`timescale 1ns / 1ps

package ccp_pkg;

	// Default polynomial length and modulus.
	localparam int DEF_COEFFS_PER_POLY = 256;
	localparam int DEF_MODULUS         = 3329;

	// Fixed field widths.
	localparam int COEFF_W = 13;
	localparam int CODE_W  = 5;
	localparam int BYTE_W  = 8;
	localparam int BUF_W   = 7;
	localparam int CNT_W   = 3;

	// Depth of the queue between the front and back parts.
	localparam int QUEUE_DEPTH = 4;

	// One classified coefficient travelling from front to back.
	typedef struct packed {
		logic [CODE_W-1:0] code;
		logic              last;
	} ccp_item_t;

endpackage

### hdl/ccp_front.sv
// Front part: accepts coefficients, reduces them once by the modulus and
// compresses them to 5-bit codes, tagging the last code of each polynomial.
// Depends on ccp_pkg.
`timescale 1ns / 1ps

module ccp_front import ccp_pkg::*; #(
	parameter int COEFFS_PER_POLY = DEF_COEFFS_PER_POLY,
	parameter int MODULUS         = DEF_MODULUS
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            coeff_valid,
	output logic                            coeff_stall,
	input  logic [COEFF_W-1:0]              coeff_value,
	input  logic [$clog2(QUEUE_DEPTH+1)-1:0] queue_level,
	output logic                            push,
	output ccp_item_t                       push_item
);

	localparam int IDX_W   = $clog2(COEFFS_PER_POLY);
	localparam int LVL_W   = $clog2(QUEUE_DEPTH+1);
	localparam int NUM_W   = COEFF_W + CODE_W + 1;
	localparam int SHIFT   = 32;
	localparam int PROD_W  = NUM_W + SHIFT;
	localparam logic [63:0] RECIP64 = ((64'd1 << SHIFT) + 64'(MODULUS) - 64'd1)
		/ 64'(MODULUS);
	localparam logic [SHIFT-1:0] RECIP = RECIP64[SHIFT-1:0];
	localparam logic [COEFF_W-1:0] Q_C = COEFF_W'(MODULUS);
	localparam logic [NUM_W-1:0] HALF_Q = NUM_W'(MODULUS / 2);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(COEFFS_PER_POLY - 1);

	logic                 accept;
	logic [LVL_W:0]       occupancy;
	logic [COEFF_W-1:0]   reduced;
	logic [NUM_W-1:0]     numer;
	logic [PROD_W-1:0]    product;
	logic [IDX_W-1:0]     idx_q;
	logic                 v_s1;
	logic                 last_s1;
	logic [NUM_W-1:0]     numer_s1;
	logic                 v_s2;
	ccp_item_t            item_s2;

	// Hold off new transactions while queued plus in-flight items could fill the queue.
	assign occupancy   = {1'b0, queue_level} + (LVL_W+1)'(v_s1) + (LVL_W+1)'(v_s2);
	assign coeff_stall = (occupancy >= (LVL_W+1)'(QUEUE_DEPTH));
	assign accept      = coeff_valid && !coeff_stall;

	// Single conditional subtraction, then scale by 32 and add half the modulus.
	always_comb begin
		reduced = (coeff_value >= Q_C) ? (coeff_value - Q_C) : coeff_value;
		numer   = {1'b0, reduced, {CODE_W{1'b0}}} + HALF_Q;
	end

	// Coefficient position within the polynomial.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (accept) begin
			idx_q <= (idx_q == LAST_IDX) ? '0 : idx_q + 1'b1;
		end
	end

	// Stage 1: numerator and last tag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			numer_s1 <= numer;
			last_s1  <= (idx_q == LAST_IDX);
		end
	end

	// Division by the constant modulus through an exact reciprocal multiply.
	assign product = PROD_W'(numer_s1) * PROD_W'(RECIP);

	// Stage 2: the low five bits of the quotient form the code.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			item_s2.code <= product[SHIFT +: CODE_W];
			item_s2.last <= last_s1;
		end
	end

	assign push      = v_s2;
	assign push_item = item_s2;

endmodule

### hdl/ccp_queue.sv
// Short queue of classified codes between the front and back parts.
// Depends on ccp_pkg.
`timescale 1ns / 1ps

module ccp_queue import ccp_pkg::*; (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             push,
	input  ccp_item_t                        push_item,
	input  logic                             pop,
	output ccp_item_t                        head,
	output logic                             empty,
	output logic [$clog2(QUEUE_DEPTH+1)-1:0] level
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int LVL_W = $clog2(QUEUE_DEPTH+1);

	ccp_item_t          entries_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [LVL_W-1:0]   level_q;

	// Pointers and fill level; the front never pushes into a full queue.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				level_q <= level_q + 1'b1;
			end else if (pop && !push) begin
				level_q <= level_q - 1'b1;
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_item;
		end
	end

	assign head  = entries_q[rd_ptr_q];
	assign empty = (level_q == '0);
	assign level = level_q;

endmodule

### hdl/ccp_back.sv
// Back part: packs 5-bit codes LSB first into bytes and holds each byte in
// an output register until the downstream side takes it.
// Depends on ccp_pkg.
`timescale 1ns / 1ps

module ccp_back import ccp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  ccp_item_t         head,
	input  logic              empty,
	output logic              pop,
	output logic              byte_valid,
	input  logic              byte_stall,
	output logic [BYTE_W-1:0] out_byte,
	output logic              out_last
);

	localparam int ACC_W = BUF_W + CODE_W;

	logic [BUF_W-1:0]  buf_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              valid_q;
	logic [BYTE_W-1:0] byte_q;
	logic              last_q;
	logic              out_free;
	logic [ACC_W-1:0]  acc;
	logic [CNT_W:0]    cnt_sum;
	logic              emit;

	// The output register can load when empty or when its transaction completes.
	assign out_free = !valid_q || !byte_stall;
	assign pop      = !empty && out_free;

	// Merge the next code above the gathered bits.
	always_comb begin
		acc     = {{CODE_W{1'b0}}, buf_q} | (ACC_W'(head.code) << cnt_q);
		cnt_sum = {1'b0, cnt_q} + (CNT_W+1)'(CODE_W);
		emit    = head.last || cnt_sum[CNT_W];
	end

	// Bit buffer and count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf_q <= '0;
			cnt_q <= '0;
		end else if (pop) begin
			if (head.last) begin
				buf_q <= '0;
				cnt_q <= '0;
			end else if (emit) begin
				buf_q <= BUF_W'(acc[ACC_W-1:BYTE_W]);
				cnt_q <= cnt_sum[CNT_W-1:0];
			end else begin
				buf_q <= acc[BUF_W-1:0];
				cnt_q <= cnt_sum[CNT_W-1:0];
			end
		end
	end

	// Output register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (out_free) begin
			valid_q <= pop && emit;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (pop && emit) begin
			byte_q <= acc[BYTE_W-1:0];
			last_q <= head.last;
		end
	end

	assign byte_valid = valid_q;
	assign out_byte   = byte_q;
	assign out_last   = last_q;

endmodule

### hdl/coeff_compress_5bit_packer.sv
// Top level of the 5-bit coefficient compress and pack block.
// Instantiates ccp_front, ccp_queue and ccp_back; depends on ccp_pkg.
//
//  Channel | Handshake               | Payload
//  --------+-------------------------+-------------------------
//  coeff   | coeff_valid/coeff_stall | coeff_value[12:0]
//  byte    | byte_valid/byte_stall   | out_byte[7:0], out_last
//
// One coefficient is taken per cycle while coeff_stall is low. A code reaches
// the head of the queue having passed an input register, a reciprocal multiply
// stage and the queue write. Its byte, if any, loads the output register on the
// edge that pops the code from the queue.
// Reset clears the pointers, bit buffer, count and coefficient position.
// A stalled output holds its byte; the four-entry queue absorbs in-flight
// codes and the input stalls only when the queue would otherwise overflow.
`timescale 1ns / 1ps

module coeff_compress_5bit_packer import ccp_pkg::*; #(
	parameter int COEFFS_PER_POLY = DEF_COEFFS_PER_POLY,
	parameter int MODULUS         = DEF_MODULUS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               coeff_valid,
	output logic               coeff_stall,
	input  logic [COEFF_W-1:0] coeff_value,
	output logic               byte_valid,
	input  logic               byte_stall,
	output logic [BYTE_W-1:0]  out_byte,
	output logic               out_last
);

	logic                             push;
	ccp_item_t                        push_item;
	logic                             pop;
	ccp_item_t                        head;
	logic                             empty;
	logic [$clog2(QUEUE_DEPTH+1)-1:0] level;

	// Front: accept and compress.
	ccp_front #(
		.COEFFS_PER_POLY(COEFFS_PER_POLY),
		.MODULUS        (MODULUS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.coeff_valid(coeff_valid),
		.coeff_stall(coeff_stall),
		.coeff_value(coeff_value),
		.queue_level(level),
		.push       (push),
		.push_item  (push_item)
	);

	// Queue between the two parts.
	ccp_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_item(push_item),
		.pop      (pop),
		.head     (head),
		.empty    (empty),
		.level    (level)
	);

	// Back: pack and emit bytes.
	ccp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.empty     (empty),
		.pop       (pop),
		.byte_valid(byte_valid),
		.byte_stall(byte_stall),
		.out_byte  (out_byte),
		.out_last  (out_last)
	);

endmodule
